@@ rtl/core/pse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg: palette scanline expander shared definitions
// Constants, register indexes and types used across the expander files.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int BYTES_PER_ITEM = 8;
    localparam int MAX_GROUPS     = 128;
    localparam int MAX_LINES      = 1024;

    localparam int NUM_LANES      = 16;   // one lane per output signal byte
    localparam int PAL_ENTRIES    = 16;
    localparam int PAL_BITS       = 6;
    localparam int GRP_W          = 7;
    localparam int LINE_W         = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAL_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAL_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_GROUPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 3'd4;

    typedef logic [PAL_ENTRIES-1:0][PAL_BITS-1:0] t_palette;

    // Position flags for one transfer
    typedef struct packed {
        logic eol;
        logic eof;
    } t_pos_flags;

    // Count limits fed to the position counter
    typedef struct packed {
        logic [7:0]  line_groups;
        logic [10:0] line_count;
    } t_limits;

endpackage
`default_nettype wire

@@ rtl/core/pse_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pse interfaces: pixel, signal and configuration channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface pse_pix_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_bytes;
    logic        frame_start;

    modport source (output valid, output pixel_bytes, output frame_start, input ready);
    modport sink   (input valid, input pixel_bytes, input frame_start, output ready);
endinterface

interface pse_sig_if;
    logic        valid;
    logic        ready;
    logic [63:0] signals_low;
    logic [63:0] signals_high;
    logic        end_of_line;
    logic        end_of_frame;

    modport source (output valid, output signals_low, output signals_high,
                    output end_of_line, output end_of_frame, input ready);
    modport sink   (input valid, input signals_low, input signals_high,
                    input end_of_line, input end_of_frame, output ready);
endinterface

interface pse_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/palette_scanline_expander_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// palette_scanline_expander_core: 4bpp palette scanline expander
// Turns 16 packed pixels per transfer into 16 VGA signal bytes.
// ----------------------------------------------------------------------------
// Each pixel transfer carries 8 frame-buffer bytes (16 pixels, high nibble
// first). Sixteen lanes look the pixels up in the 16-entry RGB222 palette in
// parallel and OR in the idle sync bits; the merge stage packs the bytes in
// I2S DMA order (adjacent 16-bit words swapped) and tags the transfer with
// end-of-line / end-of-frame from the group and line counters. Throughput is
// one transfer per clock while the signal side accepts; results leave from the output register.
// A second (skid) register keeps the pixel side accepting for one more
// transfer while the signal side stalls. Configuration writes are taken every
// cycle and must only be issued while the core is idle.
// ----------------------------------------------------------------------------
module palette_scanline_expander_core
    import pse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pse_pix_if.sink   i_pix,
    pse_cfg_if.sink   i_cfg,
    pse_sig_if.source o_sig
);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] r_pal_low, r_pal_high;
    logic [7:0]            r_sync_bits;
    logic [7:0]            r_line_groups;
    logic [10:0]           r_line_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_low     <= '0;
            r_pal_high    <= '0;
            r_sync_bits   <= '0;
            r_line_groups <= 8'd40;
            r_line_count  <= 11'd480;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PAL_LOW:     r_pal_low     <= i_cfg.data;
                REG_PAL_HIGH:    r_pal_high    <= i_cfg.data;
                REG_SYNC_BITS:   r_sync_bits   <= i_cfg.data[7:0];
                REG_LINE_GROUPS: r_line_groups <= i_cfg.data[7:0];
                REG_LINE_COUNT:  r_line_count  <= i_cfg.data[10:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    t_palette palette;
    assign palette = {r_pal_high, r_pal_low};

    // ---------------- handshake ----------------
    logic r_out_valid, r_skid_valid;
    logic pix_xfer, sig_xfer;

    assign i_pix.ready = !r_skid_valid;
    assign pix_xfer    = i_pix.valid && i_pix.ready;
    assign sig_xfer    = r_out_valid && o_sig.ready;

    // ---------------- lanes ----------------
    // Signal byte m comes from source byte (m/2)^1: the word-pair swap.
    // Even m takes the high nibble (earlier pixel), odd m the low nibble.
    logic [NUM_LANES-1:0][7:0] lane_sig;

    for (genvar m = 0; m < NUM_LANES; m++) begin : g_lane
        localparam int SRC = (m / 2) ^ 1;
        if (SRC < BYTES_PER_ITEM) begin : g_live
            localparam int NIB_LSB = 8 * SRC + ((m % 2 == 0) ? 4 : 0);
            pse_lane u_lane (
                .i_palette   (palette),
                .i_sync_bits (r_sync_bits),
                .i_nibble    (i_pix.pixel_bytes[NIB_LSB +: 4]),
                .o_signal    (lane_sig[m])
            );
        end else begin : g_empty
            // short items: no source byte, signal byte is zero
            assign lane_sig[m] = '0;
        end
    end

    // ---------------- position counter ----------------
    t_limits    limits;
    t_pos_flags flags;

    assign limits.line_groups = r_line_groups;
    assign limits.line_count  = r_line_count;

    pse_counter u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (pix_xfer),
        .i_frame_start (i_pix.frame_start),
        .i_limits      (limits),
        .o_flags       (flags)
    );

    // ---------------- merge: output register + skid ----------------
    logic [NUM_LANES*8-1:0] r_out_data,  r_skid_data,  merged;
    t_pos_flags             r_out_flags, r_skid_flags;

    assign merged = lane_sig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || sig_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= pix_xfer;
            end
        end else if (pix_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || sig_xfer) begin
            if (r_skid_valid) begin
                r_out_data  <= r_skid_data;
                r_out_flags <= r_skid_flags;
            end else if (pix_xfer) begin
                r_out_data  <= merged;
                r_out_flags <= flags;
            end
        end else if (pix_xfer) begin
            r_skid_data  <= merged;
            r_skid_flags <= flags;
        end
    end

    assign o_sig.valid        = r_out_valid;
    assign o_sig.signals_low  = r_out_data[63:0];
    assign o_sig.signals_high = r_out_data[127:64];
    assign o_sig.end_of_line  = r_out_flags.eol;
    assign o_sig.end_of_frame = r_out_flags.eof;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_eof_has_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sig.valid && o_sig.end_of_frame) |-> o_sig.end_of_line)
        else $error("end of frame without end of line");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_sig.ready) |=> r_out_valid)
        else $error("stalled result dropped");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !sig_xfer) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");

endmodule
`default_nettype wire

@@ rtl/core/pse_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pse_lane: one pixel lane
// Looks a nibble up in the palette and ORs in the idle sync bits.
// ----------------------------------------------------------------------------
module pse_lane
    import pse_pkg::*;
(
    input  wire t_palette   i_palette,
    input  wire logic [7:0] i_sync_bits,
    input  wire logic [3:0] i_nibble,
    output logic [7:0]      o_signal
);

    assign o_signal = {2'b00, i_palette[i_nibble]} | i_sync_bits;

endmodule
`default_nettype wire

@@ rtl/core/pse_counter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pse_counter: column group and line position counter
// Flags end of line / end of frame for the item being transferred.
// ----------------------------------------------------------------------------
module pse_counter
    import pse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_frame_start,
    input  wire t_limits    i_limits,
    output t_pos_flags      o_flags
);

    logic [GRP_W-1:0]  r_group, n_group;
    logic [LINE_W-1:0] r_line,  n_line;
    logic [GRP_W-1:0]  grp_base;
    logic [LINE_W-1:0] line_base;
    logic [GRP_W:0]    grp_inc, grp_lim;
    logic [LINE_W:0]   line_inc, line_lim;

    // zero counts as one, large values saturate
    always_comb begin
        if (i_limits.line_groups == '0) begin
            grp_lim = (GRP_W+1)'(1);
        end else if (i_limits.line_groups > 8'(MAX_GROUPS)) begin
            grp_lim = (GRP_W+1)'(MAX_GROUPS);
        end else begin
            grp_lim = (GRP_W+1)'(i_limits.line_groups);
        end
        if (i_limits.line_count == '0) begin
            line_lim = (LINE_W+1)'(1);
        end else if (i_limits.line_count > 11'(MAX_LINES)) begin
            line_lim = (LINE_W+1)'(MAX_LINES);
        end else begin
            line_lim = (LINE_W+1)'(i_limits.line_count);
        end
    end

    assign grp_base  = i_frame_start ? '0 : r_group;
    assign line_base = i_frame_start ? '0 : r_line;
    assign grp_inc   = {1'b0, grp_base} + (GRP_W+1)'(1);
    assign line_inc  = {1'b0, line_base} + (LINE_W+1)'(1);

    assign o_flags.eol = (grp_inc >= grp_lim);
    assign o_flags.eof = o_flags.eol && (line_inc >= line_lim);

    always_comb begin
        n_group = r_group;
        n_line  = r_line;
        if (i_step) begin
            if (o_flags.eol) begin
                n_group = '0;
                n_line  = o_flags.eof ? '0 : line_inc[LINE_W-1:0];
            end else begin
                n_group = grp_inc[GRP_W-1:0];
                n_line  = line_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_line  <= '0;
        end else begin
            r_group <= n_group;
            r_line  <= n_line;
        end
    end

endmodule
`default_nettype wire

@@ sim/pse_signal_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pse_signal_checker: expected-signal tracker for the palette expander
// Watches the pixel, config and signal channels, predicts every signal
// transfer from its own palette/counter copy and compares field by field.
// ----------------------------------------------------------------------------
module pse_signal_checker
    import pse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pse_pix_if        i_pix,
    pse_cfg_if        i_cfg,
    pse_sig_if        i_sig,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        logic [63:0] signals_low;
        logic [63:0] signals_high;
        logic        end_of_line;
        logic        end_of_frame;
    } t_signal_group;

    // shadow of the register file
    logic [CFG_DATA_W-1:0] pal_low;
    logic [CFG_DATA_W-1:0] pal_high;
    logic [7:0]            sync_mask;
    logic [7:0]            line_groups;
    logic [10:0]           line_count;

    // shadow of the position counters
    logic [GRP_W-1:0]      group_pos;
    logic [LINE_W-1:0]     line_pos;

    t_signal_group         expected_signals[$];
    int                    mismatch_count = 0;

    // 16 signal bytes, word pairs swapped: byte m comes from input byte
    // (m/2)^1, high nibble for even m
    function automatic logic [127:0] expand_lanes(input logic [63:0] bytes_in);
        logic [127:0]          lanes;
        int                    src;
        logic [7:0]            src_byte;
        logic [3:0]            nib;
        logic [CFG_DATA_W-1:0] bank;
        lanes = '0;
        for (int m = 0; m < NUM_LANES; m++) begin
            src = (m >> 1) ^ 1;
            if (src < BYTES_PER_ITEM) begin
                src_byte = bytes_in[8*src +: 8];
                nib      = (m & 1) ? src_byte[3:0] : src_byte[7:4];
                bank     = nib[3] ? pal_high : pal_low;
                lanes[8*m +: 8] = {2'b00, bank[PAL_BITS*nib[2:0] +: PAL_BITS]} | sync_mask;
            end
        end
        return lanes;
    endfunction

    function automatic int clamp_limit(input int value, input int ceiling);
        if (value == 0)
            return 1;
        if (value > ceiling)
            return ceiling;
        return value;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %h, got %h", field, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_signal_group predicted;
        logic [127:0]  lanes;
        int            groups_lim;
        int            lines_lim;
        if (!i_rst_n) begin
            pal_low     = '0;
            pal_high    = '0;
            sync_mask   = '0;
            line_groups = 8'd40;
            line_count  = 11'd480;
            group_pos   = '0;
            line_pos    = '0;
            expected_signals.delete();
        end else begin
            // pixel transfer: predict its signal transfer
            if (i_pix.valid && i_pix.ready) begin
                lanes                  = expand_lanes(i_pix.pixel_bytes);
                predicted.signals_low  = lanes[63:0];
                predicted.signals_high = lanes[127:64];
                predicted.end_of_line  = 1'b0;
                predicted.end_of_frame = 1'b0;
                if (i_pix.frame_start) begin
                    group_pos = '0;
                    line_pos  = '0;
                end
                groups_lim = clamp_limit(int'(line_groups), MAX_GROUPS);
                lines_lim  = clamp_limit(int'(line_count), MAX_LINES);
                // >= so a limit lowered below the count wraps at once
                if (int'(group_pos) + 1 >= groups_lim) begin
                    group_pos             = '0;
                    predicted.end_of_line = 1'b1;
                    if (int'(line_pos) + 1 >= lines_lim) begin
                        line_pos               = '0;
                        predicted.end_of_frame = 1'b1;
                    end else begin
                        line_pos = line_pos + 1'b1;
                    end
                end else begin
                    group_pos = group_pos + 1'b1;
                end
                expected_signals.push_back(predicted);
            end

            // signal transfer: compare with the oldest prediction
            if (i_sig.valid && i_sig.ready) begin
                if (expected_signals.size() == 0) begin
                    $error("signal transfer with nothing expected: low %h high %h",
                           i_sig.signals_low, i_sig.signals_high);
                    mismatch_count++;
                end else begin
                    predicted = expected_signals.pop_front();
                    check_field("signals_low", predicted.signals_low, i_sig.signals_low);
                    check_field("signals_high", predicted.signals_high, i_sig.signals_high);
                    check_field("end_of_line", 64'(predicted.end_of_line),
                                64'(i_sig.end_of_line));
                    check_field("end_of_frame", 64'(predicted.end_of_frame),
                                64'(i_sig.end_of_frame));
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_PAL_LOW:     pal_low     = i_cfg.data;
                    REG_PAL_HIGH:    pal_high    = i_cfg.data;
                    REG_SYNC_BITS:   sync_mask   = i_cfg.data[7:0];
                    REG_LINE_GROUPS: line_groups = i_cfg.data[7:0];
                    REG_LINE_COUNT:  line_count  = i_cfg.data[10:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_signals.size();
        o_errors  <= mismatch_count;
    end

endmodule

@@ sim/palette_scanline_expander_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_scanline_expander_core_test: expander core testbench
// Directed and random pixel transfers across register settings, with
// random idling on both channels and a long output stall; a separate
// checker predicts and compares every signal transfer.
// ----------------------------------------------------------------------------
module palette_scanline_expander_core_test
    import pse_pkg::*;
();

    localparam int CLK_HALF      = 4;     // 8 ns clock
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int LONG_HOLD     = 300;   // receiver hold-off, well under the limit
    localparam int SETTLE_CYCLES = 8;     // settle margin after the final drain

    // first index past the register file; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_LINE_COUNT + 3'd1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pse_pix_if pix_bus ();
    pse_cfg_if cfg_bus ();
    pse_sig_if sig_bus ();

    int errors;
    int pending;

    // idle rates in percent, changed by the stimulus with NBAs
    int src_idle_pct  = 22;
    int sink_idle_pct = 69;

    // long hold-off request: stimulus bumps req, receiver follows with ack
    int   hold_req_seq = 0;
    int   hold_ack_seq = 0;
    int   hold_left    = 0;
    logic sink_ready   = 1'b0;
    int   quiet_cycles = 0;

    assign sig_bus.ready = sink_ready;

    palette_scanline_expander_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_sig   (sig_bus)
    );

    pse_signal_checker u_signal_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_bus),
        .i_cfg     (cfg_bus),
        .i_sig     (sig_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, or held low on request until the hold-off runs out.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            hold_left  <= 0;
        end else if (hold_ack_seq != hold_req_seq) begin
            hold_ack_seq <= hold_req_seq;
            hold_left    <= LONG_HOLD;
            sink_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transfer on any channel restarts the count.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_bus.valid && pix_bus.ready) ||
            (sig_bus.valid && sig_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel transfer, idling first at the current sender rate.
    // Returns at the edge where the transfer happened.
    task automatic push_group(input logic [63:0] bytes_in, input logic frame_first);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_bytes <= bytes_in;
        pix_bus.frame_start <= frame_first;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every predicted signal transfer to arrive.
    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // valid stays high between back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // Full reprogram while idle. Unused upper data bits carry noise, which the
    // core must mask; one spare index gets a write that must change nothing.
    task automatic set_config(input logic [CFG_DATA_W-1:0] pal_lo,
                              input logic [CFG_DATA_W-1:0] pal_hi,
                              input logic [7:0] sync,
                              input logic [7:0] groups,
                              input logic [10:0] lines);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'({$urandom, $urandom});
        drain_results();
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(2)), noise);
        write_reg(REG_PAL_LOW, pal_lo);
        write_reg(REG_PAL_HIGH, pal_hi);
        write_reg(REG_SYNC_BITS, {noise[CFG_DATA_W-1:8], sync});
        write_reg(REG_LINE_GROUPS, {noise[CFG_DATA_W-1:8], groups});
        write_reg(REG_LINE_COUNT, {noise[CFG_DATA_W-1:11], lines});
        cfg_bus.valid <= 1'b0;
    endtask

    // Frames of random pixels: frame_start on the first transfer (if asked)
    // and rarely mid-frame; some transfers repeat one nibble or byte.
    task automatic random_frames(input int count, input logic first_fs);
        logic [63:0] bytes_v;
        logic        fs;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(7))
                0:       bytes_v = {16{4'($urandom)}};
                1:       bytes_v = {8{8'($urandom)}};
                default: bytes_v = {$urandom, $urandom};
            endcase
            fs = (k == 0) ? first_fs : ($urandom_range(99) < 3);
            push_group(bytes_v, fs);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_palette();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_bytes <= '0;
        pix_bus.frame_start <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_PAL_LOW;
        cfg_bus.data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: empty palette, 40 groups per line, nothing ends
        push_group(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        push_group(64'h0123_4567_89AB_CDEF, 1'b0);

        // distinct palette, sync bits above the RGB field, 4 groups x 2 lines
        set_config(48'h5A3C_F0E1_D2C4, 48'hFFF0_0F0F_1234, 8'hC0, 8'd4, 11'd2);
        push_group(64'h0000_0000_0000_0000, 1'b1);
        push_group(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_group(64'h0123_4567_89AB_CDEF, 1'b0);
        push_group(64'hFEDC_BA98_7654_3210, 1'b0);
        push_group(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
        push_group(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);   // restart mid-line
        push_group(64'h8000_0000_0000_0001, 1'b0);
        push_group(64'hA5A5_5A5A_A5A5_5A5A, 1'b0);
        push_group(64'h7777_8888_7777_8888, 1'b0);
        push_group(64'h1122_3344_5566_7788, 1'b0);
        push_group(64'h99AA_BBCC_DDEE_FF00, 1'b0);
        push_group(64'h0000_0000_0000_0000, 1'b0);

        // zero widths count as one: every transfer ends line and frame
        set_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 8'hFF, 8'd0, 11'd0);
        push_group(64'h0123_4567_89AB_CDEF, 1'b0);
        push_group(64'hFEDC_BA98_7654_3210, 1'b1);
        push_group(64'h5555_AAAA_5555_AAAA, 1'b0);

        // oversize widths saturate
        set_config('0, '0, 8'h00, 8'd255, 11'd2047);
        push_group(64'hFFFF_0000_FFFF_0000, 1'b1);
        push_group(64'h0000_FFFF_0000_FFFF, 1'b0);
        push_group(64'h3C3C_C3C3_3C3C_C3C3, 1'b0);

        // -------- sender idles 22%, receiver 69% --------
        set_config(rand_palette(), rand_palette(), 8'h00, 8'd1, 11'd1);
        random_frames(60, 1'b1);
        set_config(rand_palette(), rand_palette(), 8'hC0, 8'd3, 11'd4);
        random_frames(120, 1'b1);
        set_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 8'hFF, 8'd128, 11'd1);
        random_frames(140, 1'b1);

        // -------- sender idles 69%, receiver 22% --------
        drain_results();
        src_idle_pct  <= 69;
        sink_idle_pct <= 22;
        set_config(rand_palette(), rand_palette(), 8'($urandom), 8'd100, 11'd1024);
        random_frames(60, 1'b1);
        // lower the group limit under the running group count: next transfer wraps
        set_config(rand_palette(), rand_palette(), 8'($urandom), 8'd5, 11'd3);
        random_frames(120, 1'b0);
        set_config('0, '0, 8'($urandom), 8'd2, 11'd7);
        random_frames(110, 1'b1);

        // -------- no idling on either side --------
        drain_results();
        src_idle_pct  <= 0;
        sink_idle_pct <= 0;
        set_config(rand_palette(), rand_palette(), 8'($urandom), 8'd128, 11'd2);
        // receiver holds off while the sender keeps offering: core fills up
        hold_req_seq <= hold_req_seq + 1;
        random_frames(200, 1'b1);
        // pause with nothing outstanding, then carry on in the same frame
        drain_results();
        random_frames(100, 1'b0);
        set_config(rand_palette(), rand_palette(), 8'($urandom), 8'd1, 11'd1024);
        random_frames(120, 1'b1);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
